// ===== hdl/cts_pkg.sv =====
// Shared types and constants for the compact table support engine.
// No dependencies; imported by cts_word_alu, compact_table_support_engine and its testbench.
`timescale 1ns / 1ps

package cts_pkg;

   // Default sizing of the constraint tables.
   localparam int WORDS_DEFAULT      = 16;
   localparam int MAX_VARS_DEFAULT   = 8;
   localparam int MAX_VALUES_DEFAULT = 64;

   // Fixed field widths of a transaction.
   localparam int WORD_W     = 64;
   localparam int BIT_POS_W  = 6;
   localparam int REQ_TYPE_W = 2;
   localparam int VAR_W      = 3;
   localparam int VALUE_W    = 6;
   localparam int TUPLE_W    = 10;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_SET_MASK = 2'd0,
      REQ_ACTIVATE = 2'd1,
      REQ_REMOVE   = 2'd2,
      REQ_QUERY    = 2'd3
   } req_code_type;

   typedef enum logic {
      ALU_MERGE,
      ALU_CLEAR
   } alu_op_type;

   typedef struct packed {
      logic hit;
      logic nonzero;
   } alu_flags_type;

endpackage

// ===== hdl/cts_word_alu.sv =====
// Shared 64-bit word unit: merges a bit into a word, or clears a mask out of
// a word and reports whether the two operands intersect. Depends on cts_pkg.
`timescale 1ns / 1ps

module cts_word_alu import cts_pkg::*; (
   input  alu_op_type          op,
   input  logic [WORD_W-1:0]   operand_a,
   input  logic [WORD_W-1:0]   operand_b,
   output logic [WORD_W-1:0]   result,
   output alu_flags_type       flags
);

   always_comb begin
      if (op == ALU_MERGE) begin
         result = operand_b | operand_a;
      end else begin
         result = operand_b & ~operand_a;
      end
      flags.hit     = |(operand_a & operand_b);
      flags.nonzero = |result;
   end

endmodule

// ===== hdl/compact_table_support_engine.sv =====
// Top level of the compact table support engine: sequencer, mask, active-set
// and residue memories. Depends on cts_pkg and cts_word_alu.
`timescale 1ns / 1ps

// The engine holds, for every (variable, value) pair, a bit mask of the tuples
// that take that value, plus the set of active tuples, and serves one
// transaction at a time: start is taken when busy is low, and exactly one
// result follows, shown for a single cycle with rsp_strobe high. The receiver
// cannot stall the result, so it must capture it in that cycle. After reset
// the engine clears its mask and residue memories, one mask word per cycle,
// keeping busy high throughout. Setting a mask bit or activating a tuple
// passes through a read state, a write state and the finish state, and the
// result is strobed in the cycle that follows busy. Removing a value keeps
// busy high while the shared word unit walks the value's mask one 64-bit
// word per cycle against the active set. A support query goes through the
// residue fetch, issue and check states and ends when the stored residue
// word still hits; else it falls back to the full word scan, which stops at
// the first hit and records that word as the new residue. Set, remove and
// query requests naming a variable or value outside the configured range,
// and set or activate requests naming a tuple at or beyond 64*WORDS, change
// nothing and report supported and changed as zero; rsp_empty_res always
// tells whether any active tuple remains after the transaction.

module compact_table_support_engine import cts_pkg::*; #(
   parameter int WORDS      = WORDS_DEFAULT,
   parameter int MAX_VARS   = MAX_VARS_DEFAULT,
   parameter int MAX_VALUES = MAX_VALUES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [REQ_TYPE_W-1:0] req_type,
   input  logic [VAR_W-1:0]      req_var_index,
   input  logic [VALUE_W-1:0]    req_value_index,
   input  logic [TUPLE_W-1:0]    req_tuple_index,
   output logic                  rsp_strobe,
   output logic                  rsp_supported,
   output logic                  rsp_changed,
   output logic                  rsp_empty_res
);

   localparam int PAIRS  = MAX_VARS * MAX_VALUES;
   localparam int DEPTH  = PAIRS * WORDS;
   localparam int PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WIDX   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int ISS_W  = $clog2(WORDS + 1);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SET_RD,
      ST_SET_WR,
      ST_ACT_RD,
      ST_ACT_WR,
      ST_RES_FETCH,
      ST_RES_ISSUE,
      ST_RES_CHECK,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Control and registered outputs.
   state_type              state_ff, state_in;
   req_code_type           req_ff, req_in;
   logic [PAIR_W-1:0]      pair_ff, pair_in;
   logic [WIDX-1:0]        word_ff, word_in;
   logic [BIT_POS_W-1:0]   bitpos_ff, bitpos_in;
   logic [ADDR_W-1:0]      clr_ff, clr_in;
   logic [ISS_W-1:0]       iss_ff, iss_in;
   logic                   pend_ff, pend_in;
   logic [WIDX-1:0]        cur_ff, cur_in;
   logic                   supported_ff, supported_in;
   logic                   changed_ff, changed_in;
   logic [WORDS-1:0]       nz_ff, nz_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic                   rsp_supported_ff, rsp_supported_in;
   logic                   rsp_changed_ff, rsp_changed_in;
   logic                   rsp_empty_ff, rsp_empty_in;

   // Memories and their registered read data.
   logic [WORD_W-1:0]      mask_mem [DEPTH];
   logic [WORD_W-1:0]      act_mem [WORDS];
   logic [WIDX-1:0]        res_mem [PAIRS];
   logic [WORD_W-1:0]      mask_q;
   logic [WORD_W-1:0]      act_q;
   logic                   act_nz_q;
   logic [WIDX-1:0]        res_q;

   // Memory port controls.
   logic [ADDR_W-1:0]      base_addr;
   logic [WIDX-1:0]        iss_idx;
   logic [ADDR_W-1:0]      mask_raddr, mask_waddr;
   logic                   mask_we;
   logic [WORD_W-1:0]      mask_wdata;
   logic [WIDX-1:0]        act_raddr, act_waddr;
   logic                   act_we;
   logic                   res_we;
   logic [PAIR_W-1:0]      res_waddr;
   logic [WIDX-1:0]        res_wdata;
   logic                   res_ok;

   // Shared word unit.
   alu_op_type             alu_op;
   logic [WORD_W-1:0]      alu_a, alu_b, alu_result;
   alu_flags_type          alu_flags;
   logic [WORD_W-1:0]      act_word, bit_word;

   // Request decode at accept.
   logic                   pair_ok, tup_ok;

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_supported = rsp_supported_ff;
   assign rsp_changed   = rsp_changed_ff;
   assign rsp_empty_res = rsp_empty_ff;

   // A word whose nonzero flag is clear reads as zero, so the active set
   // needs no clearing pass: the flags alone are reset.
   assign act_word  = act_nz_q ? act_q : '0;
   assign bit_word  = WORD_W'(1) << bitpos_ff;
   assign base_addr = ADDR_W'(pair_ff * WORDS);
   assign iss_idx   = iss_ff[WIDX-1:0];
   assign res_ok    = (32'(res_q) < WORDS);

   assign pair_ok = (32'(req_var_index) < MAX_VARS) && (32'(req_value_index) < MAX_VALUES);
   assign tup_ok  = (32'(req_tuple_index >> BIT_POS_W) < WORDS);

   cts_word_alu u_alu (
      .op        (alu_op),
      .operand_a (alu_a),
      .operand_b (alu_b),
      .result    (alu_result),
      .flags     (alu_flags)
   );

   // Word unit operand selection.
   always_comb begin
      if (state_ff inside {ST_SET_WR, ST_ACT_WR}) begin
         alu_op = ALU_MERGE;
         alu_a  = bit_word;
      end else begin
         alu_op = ALU_CLEAR;
         alu_a  = mask_q;
      end
      alu_b = (state_ff == ST_SET_WR) ? mask_q : act_word;
   end

   // Memory addressing.
   always_comb begin
      case (state_ff)
         ST_SET_RD: begin
            mask_raddr = base_addr + ADDR_W'(word_ff);
            act_raddr  = word_ff;
         end
         ST_RES_ISSUE: begin
            mask_raddr = base_addr + ADDR_W'(res_q);
            act_raddr  = res_q;
         end
         ST_SCAN: begin
            mask_raddr = base_addr + ADDR_W'(iss_idx);
            act_raddr  = iss_idx;
         end
         default: begin
            mask_raddr = base_addr;
            act_raddr  = word_ff;
         end
      endcase

      mask_we    = state_ff inside {ST_CLEAR, ST_SET_WR};
      mask_waddr = (state_ff == ST_CLEAR) ? clr_ff : base_addr + ADDR_W'(word_ff);
      mask_wdata = (state_ff == ST_CLEAR) ? '0 : alu_result;

      act_we    = (state_ff == ST_ACT_WR) ||
                  (state_ff == ST_SCAN && pend_ff && req_ff == REQ_REMOVE && alu_flags.hit);
      act_waddr = (state_ff == ST_ACT_WR) ? word_ff : cur_ff;

      res_we    = (state_ff == ST_CLEAR && 32'(clr_ff) < PAIRS) ||
                  (state_ff == ST_SCAN && pend_ff && req_ff == REQ_QUERY && alu_flags.hit);
      res_waddr = (state_ff == ST_CLEAR) ? clr_ff[PAIR_W-1:0] : pair_ff;
      res_wdata = (state_ff == ST_CLEAR) ? '0 : cur_ff;
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in         = state_ff;
      req_in           = req_ff;
      pair_in          = pair_ff;
      word_in          = word_ff;
      bitpos_in        = bitpos_ff;
      clr_in           = clr_ff;
      iss_in           = iss_ff;
      pend_in          = pend_ff;
      cur_in           = cur_ff;
      supported_in     = supported_ff;
      changed_in       = changed_ff;
      nz_in            = nz_ff;
      rsp_strobe_in    = 1'b0;
      rsp_supported_in = rsp_supported_ff;
      rsp_changed_in   = rsp_changed_ff;
      rsp_empty_in     = rsp_empty_ff;

      if (act_we) begin
         nz_in[act_waddr] = alu_flags.nonzero;
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               req_in       = req_code_type'(req_type);
               pair_in      = PAIR_W'(int'(req_var_index) * MAX_VALUES + int'(req_value_index));
               word_in      = WIDX'(req_tuple_index >> BIT_POS_W);
               bitpos_in    = req_tuple_index[BIT_POS_W-1:0];
               supported_in = 1'b0;
               changed_in   = 1'b0;
               iss_in       = '0;
               pend_in      = 1'b0;
               case (req_code_type'(req_type))
                  REQ_SET_MASK: state_in = (pair_ok && tup_ok) ? ST_SET_RD : ST_FINISH;
                  REQ_ACTIVATE: state_in = tup_ok ? ST_ACT_RD : ST_FINISH;
                  REQ_REMOVE:   state_in = pair_ok ? ST_SCAN : ST_FINISH;
                  default:      state_in = pair_ok ? ST_RES_FETCH : ST_FINISH;
               endcase
            end
         end
         ST_SET_RD:    state_in = ST_SET_WR;
         ST_SET_WR:    state_in = ST_FINISH;
         ST_ACT_RD:    state_in = ST_ACT_WR;
         ST_ACT_WR:    state_in = ST_FINISH;
         ST_RES_FETCH: state_in = ST_RES_ISSUE;
         ST_RES_ISSUE: state_in = ST_RES_CHECK;
         ST_RES_CHECK: begin
            if (res_ok && alu_flags.hit) begin
               supported_in = 1'b1;
               state_in     = ST_FINISH;
            end else begin
               iss_in   = '0;
               pend_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Reads are issued for word iss while the word unit works on word cur,
            // the word read in the cycle before.
            if (iss_ff < ISS_W'(WORDS)) begin
               pend_in = 1'b1;
               cur_in  = iss_idx;
               iss_in  = iss_ff + ISS_W'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (req_ff == REQ_REMOVE) begin
                  if (alu_flags.hit) begin
                     changed_in = 1'b1;
                  end
                  if (iss_ff == ISS_W'(WORDS)) begin
                     state_in = ST_FINISH;
                  end
               end else if (alu_flags.hit) begin
                  supported_in = 1'b1;
                  state_in     = ST_FINISH;
               end else if (iss_ff == ISS_W'(WORDS)) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            rsp_strobe_in    = 1'b1;
            rsp_supported_in = supported_ff;
            rsp_changed_in   = changed_ff;
            rsp_empty_in     = ~|nz_ff;
            state_in         = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_ff           <= '0;
         pend_ff          <= 1'b0;
         nz_ff            <= '0;
         rsp_strobe_ff    <= 1'b0;
         rsp_supported_ff <= 1'b0;
         rsp_changed_ff   <= 1'b0;
         rsp_empty_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         clr_ff           <= clr_in;
         pend_ff          <= pend_in;
         nz_ff            <= nz_in;
         rsp_strobe_ff    <= rsp_strobe_in;
         rsp_supported_ff <= rsp_supported_in;
         rsp_changed_ff   <= rsp_changed_in;
         rsp_empty_ff     <= rsp_empty_in;
      end
      req_ff       <= req_in;
      pair_ff      <= pair_in;
      word_ff      <= word_in;
      bitpos_ff    <= bitpos_in;
      iss_ff       <= iss_in;
      cur_ff       <= cur_in;
      supported_ff <= supported_in;
      changed_ff   <= changed_in;
   end

   // Value masks: one write and one read port, registered read data.
   always_ff @(posedge clock) begin
      if (mask_we) begin
         mask_mem[mask_waddr] <= mask_wdata;
      end
      mask_q <= mask_mem[mask_raddr];
   end

   // Active tuple words, qualified by their nonzero flags.
   always_ff @(posedge clock) begin
      if (act_we) begin
         act_mem[act_waddr] <= alu_result;
      end
      act_q    <= act_mem[act_raddr];
      act_nz_q <= nz_ff[act_raddr];
   end

   // Residue word per (variable, value) pair.
   always_ff @(posedge clock) begin
      if (res_we) begin
         res_mem[res_waddr] <= res_wdata;
      end
      res_q <= res_mem[pair_ff];
   end

`ifndef SYNTH
   // A result is only ever shown while the engine is ready for the next one.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // An accepted transaction always leaves the engine busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("engine not busy after accepting a transaction");

   // A query never removes tuples and a removal never reports support.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_supported && rsp_changed))
      else $error("supported and changed both set");

   // Support implies that at least one active tuple is left.
   a_support_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_supported) |-> !rsp_empty_res)
      else $error("supported value reported with an empty active set");
`endif

endmodule

// ===== tb/sv/compact_table_support_engine_test.sv =====
// Self-checking testbench for the compact table support engine.
// Depends on cts_pkg and compact_table_support_engine; holds the outcome tracker class.
`timescale 1ns / 1ps

module compact_table_support_engine_test;
   import cts_pkg::*;

   // Sizing follows the package defaults that the instance below also uses.
   localparam int WORDS      = WORDS_DEFAULT;
   localparam int MAX_VARS   = MAX_VARS_DEFAULT;
   localparam int MAX_VALUES = MAX_VALUES_DEFAULT;
   localparam int PAIR_COUNT = MAX_VARS * MAX_VALUES;

   // The clearing pass after reset alone writes PAIR_COUNT*WORDS mask words
   // with busy high; the watchdog allows several times that with no traffic.
   localparam int STALL_LIMIT = 5 * PAIR_COUNT * WORDS;
   // The slowest transaction is a query that falls back to the full scan.
   localparam int TAIL_CYCLES = WORDS + 16;
   localparam int PHASES      = 5;
   localparam int PHASE_ITEMS = 300;

   typedef struct packed {
      req_code_type         code;
      logic [VAR_W-1:0]     var_idx;
      logic [VALUE_W-1:0]   val_idx;
      logic [TUPLE_W-1:0]   tup_idx;
   } cts_request_type;

   typedef struct packed {
      logic supported;
      logic changed;
      logic empty_res;
   } cts_outcome_type;

   // The tracker keeps its own copy of the mask table, the active tuple set
   // and the residue words. Each accepted transaction updates that copy and
   // queues the outcome the engine must report; each strobed result is then
   // compared with the oldest queued outcome.
   class cts_outcome_tracker_type;
      bit [WORD_W-1:0] value_mask [PAIR_COUNT][WORDS];
      bit [WORD_W-1:0] active_set [WORDS];
      int unsigned     residue [PAIR_COUNT];
      cts_outcome_type pending_outcomes [$];
      int unsigned     mismatch_count;

      function new();
         mismatch_count = 0;
      endfunction

      function int pending_count();
         return pending_outcomes.size();
      endfunction

      function void note_request(cts_request_type rq);
         int unsigned     pair;
         int unsigned     word;
         bit              pair_ok;
         bit              tuple_ok;
         bit [WORD_W-1:0] bit_sel;
         cts_outcome_type res;
         pair_ok  = (int'(rq.var_idx) < MAX_VARS) && (int'(rq.val_idx) < MAX_VALUES);
         pair     = pair_ok ? int'(rq.var_idx) * MAX_VALUES + int'(rq.val_idx) : 0;
         word     = int'(rq.tup_idx) >> BIT_POS_W;
         tuple_ok = word < WORDS;
         bit_sel  = WORD_W'(1) << rq.tup_idx[BIT_POS_W-1:0];
         res      = '0;
         case (rq.code)
            REQ_SET_MASK: begin
               if (pair_ok && tuple_ok) value_mask[pair][word] |= bit_sel;
            end
            REQ_ACTIVATE: begin
               if (tuple_ok) active_set[word] |= bit_sel;
            end
            REQ_REMOVE: begin
               if (pair_ok) begin
                  for (int w = 0; w < WORDS; w++) begin
                     if ((value_mask[pair][w] & active_set[w]) != '0) begin
                        active_set[w] &= ~value_mask[pair][w];
                        res.changed = 1'b1;
                     end
                  end
               end
            end
            default: begin
               // The residue only shortens the search; a stale one falls
               // back to the full scan, which records the first word that hits.
               if (pair_ok) begin
                  if (residue[pair] < WORDS &&
                      (value_mask[pair][residue[pair]] & active_set[residue[pair]]) != '0) begin
                     res.supported = 1'b1;
                  end else begin
                     for (int w = 0; w < WORDS; w++) begin
                        if ((value_mask[pair][w] & active_set[w]) != '0) begin
                           residue[pair] = w;
                           res.supported = 1'b1;
                           break;
                        end
                     end
                  end
               end
            end
         endcase
         res.empty_res = 1'b1;
         for (int w = 0; w < WORDS; w++) begin
            if (active_set[w] != '0) res.empty_res = 1'b0;
         end
         pending_outcomes.insert(pending_outcomes.size(), res);
      endfunction

      function void check_result(logic supported, logic changed, logic empty_res);
         cts_outcome_type want;
         if (pending_outcomes.size() == 0) begin
            $error("result strobe with no transaction outstanding");
            mismatch_count++;
            return;
         end
         want = pending_outcomes.pop_front();
         if (supported !== want.supported) begin
            $error("rsp_supported: expected %0d, actual %0d", want.supported, supported);
            mismatch_count++;
         end
         if (changed !== want.changed) begin
            $error("rsp_changed: expected %0d, actual %0d", want.changed, changed);
            mismatch_count++;
         end
         if (empty_res !== want.empty_res) begin
            $error("rsp_empty_res: expected %0d, actual %0d", want.empty_res, empty_res);
            mismatch_count++;
         end
      endfunction
   endclass

   // Every input starts at a known value; reset is held from time zero.
   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  start           = 1'b0;
   logic [REQ_TYPE_W-1:0] req_type        = '0;
   logic [VAR_W-1:0]      req_var_index   = '0;
   logic [VALUE_W-1:0]    req_value_index = '0;
   logic [TUPLE_W-1:0]    req_tuple_index = '0;
   logic                  busy;
   logic                  rsp_strobe;
   logic                  rsp_supported;
   logic                  rsp_changed;
   logic                  rsp_empty_res;

   cts_outcome_tracker_type tracker;
   cts_request_type         seen_req;
   cts_request_type         directed [$];
   int unsigned             quiet_cycles = 0;

   compact_table_support_engine #(
      .WORDS      (WORDS),
      .MAX_VARS   (MAX_VARS),
      .MAX_VALUES (MAX_VALUES)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_var_index   (req_var_index),
      .req_value_index (req_value_index),
      .req_tuple_index (req_tuple_index),
      .rsp_strobe      (rsp_strobe),
      .rsp_supported   (rsp_supported),
      .rsp_changed     (rsp_changed),
      .rsp_empty_res   (rsp_empty_res)
   );

   always #4 clock = ~clock;

   // All stimulus changes with nonblocking assignments at the rising edge, so
   // the values read here at an edge are the ones the engine saw at that edge.
   // A result strobed at the same edge as a new acceptance belongs to an older
   // transaction, and the queue order keeps the two apart.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe === 1'b1) tracker.check_result(rsp_supported, rsp_changed, rsp_empty_res);
         if (start && busy === 1'b0) begin
            seen_req.code    = req_code_type'(req_type);
            seen_req.var_idx = req_var_index;
            seen_req.val_idx = req_value_index;
            seen_req.tup_idx = req_tuple_index;
            tracker.note_request(seen_req);
         end
      end
   end

   // The watchdog restarts on any accepted transaction or result. A hung
   // handshake or a result that never arrives ends the run here.
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("compact_table_support_engine: mismatch");
         $finish;
      end
   end

   function automatic cts_request_type make_req(req_code_type code, int unsigned var_idx,
                                                int unsigned val_idx, int unsigned tup_idx);
      cts_request_type rq;
      rq.code    = code;
      rq.var_idx = VAR_W'(var_idx);
      rq.val_idx = VALUE_W'(val_idx);
      rq.tup_idx = TUPLE_W'(tup_idx);
      return rq;
   endfunction

   // Appends one transaction to the directed list.
   function automatic void queue_directed(cts_request_type rq);
      directed.insert(directed.size(), rq);
   endfunction

   // Most random transactions work on a few pairs and a pool of tuples spread
   // over every word, so masks really meet the active set and queries,
   // removals and the empty flag all see both outcomes. The remainder is noise
   // over the full range of every field.
   function automatic cts_request_type random_request();
      cts_request_type rq;
      int unsigned     pick;
      if ($urandom_range(99) < 20) begin
         rq = make_req(req_code_type'(REQ_TYPE_W'($urandom_range(3))), $urandom_range(7),
                       $urandom_range(63), $urandom_range(1023));
      end else begin
         pick = $urandom_range(99);
         if (pick < 30) rq.code = REQ_SET_MASK;
         else if (pick < 55) rq.code = REQ_ACTIVATE;
         else if (pick < 70) rq.code = REQ_REMOVE;
         else rq.code = REQ_QUERY;
         rq.var_idx = VAR_W'($urandom_range(2));
         rq.val_idx = VALUE_W'($urandom_range(3));
         rq.tup_idx = TUPLE_W'($urandom_range(WORDS - 1) * WORD_W + $urandom_range(7));
      end
      return rq;
   endfunction

   // Presents one transaction and returns right after the edge that took it.
   // Start stays high; the caller lowers it only when it chooses to idle.
   task automatic issue(input cts_request_type rq);
      start           <= 1'b1;
      req_type        <= rq.code;
      req_var_index   <= rq.var_idx;
      req_value_index <= rq.val_idx;
      req_tuple_index <= rq.tup_idx;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Inserts a random run of idle steps, each one taken with a chance of 21 in 100;
   // each idle step holds start low up to and through an edge with busy low.
   task automatic sender_gap(input bit allowed);
      if (allowed) begin
         while ($urandom_range(99) < 21) begin
            start <= 1'b0;
            do @(posedge clock); while (busy !== 1'b0);
         end
      end
   endtask

   // Holds the sender off until every outstanding result has come back.
   // It always waits for an edge first, so start never gets two assignments in a step.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (tracker.pending_count() != 0);
   endtask

   initial begin
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed transactions: extreme field values, every request type, a
      // query while no tuple is active, a query of a value whose mask is empty,
      // a residue hit, a stale residue that forces the full scan, a removal
      // that changes nothing, and a removal that leaves the active set empty.
      queue_directed(make_req(REQ_SET_MASK, 0, 0, 0));
      queue_directed(make_req(REQ_SET_MASK, 7, 63, 1023));
      queue_directed(make_req(REQ_SET_MASK, 5, 42, 682));
      queue_directed(make_req(REQ_QUERY, 0, 0, 0));
      queue_directed(make_req(REQ_QUERY, 3, 5, 1023));
      queue_directed(make_req(REQ_ACTIVATE, 0, 0, 0));
      queue_directed(make_req(REQ_ACTIVATE, 7, 63, 1023));
      queue_directed(make_req(REQ_ACTIVATE, 2, 21, 341));
      queue_directed(make_req(REQ_QUERY, 0, 0, 0));
      queue_directed(make_req(REQ_QUERY, 7, 63, 0));
      queue_directed(make_req(REQ_QUERY, 7, 63, 0));
      queue_directed(make_req(REQ_SET_MASK, 7, 63, 64));
      queue_directed(make_req(REQ_ACTIVATE, 0, 0, 64));
      queue_directed(make_req(REQ_SET_MASK, 2, 1, 1023));
      queue_directed(make_req(REQ_REMOVE, 2, 1, 0));
      queue_directed(make_req(REQ_QUERY, 7, 63, 0));
      queue_directed(make_req(REQ_REMOVE, 3, 5, 0));
      queue_directed(make_req(REQ_REMOVE, 0, 0, 0));
      queue_directed(make_req(REQ_REMOVE, 0, 0, 1023));
      queue_directed(make_req(REQ_QUERY, 5, 42, 682));
      queue_directed(make_req(REQ_REMOVE, 7, 63, 0));
      queue_directed(make_req(REQ_SET_MASK, 5, 21, 341));
      queue_directed(make_req(REQ_REMOVE, 5, 21, 0));
      queue_directed(make_req(REQ_QUERY, 5, 21, 341));
      foreach (directed[i]) begin
         issue(directed[i]);
         sender_gap(1'b1);
      end
      drain();

      // Random phases. The middle phase runs without any idle cycles, and the
      // sender waits for every result at the end of each phase.
      for (int phase = 0; phase < PHASES; phase++) begin
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            issue(random_request());
            sender_gap(phase != 2);
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatch_count == 0) begin
         $display("compact_table_support_engine: match");
      end else begin
         $display("compact_table_support_engine: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/cts_pkg.sv
hdl/cts_word_alu.sv
hdl/compact_table_support_engine.sv
tb/sv/compact_table_support_engine_test.sv
